// ----- rtl/nrg_pkg.sv -----
// shared types, register map and saturation helper for the narma generator
// no dependencies; used by the channel interfaces and the top level
package nrg_pkg;

    typedef logic signed [31:0] q16_t;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_COEFF_A = 3'd0;
    localparam logic [2:0] REG_COEFF_B = 3'd1;
    localparam logic [2:0] REG_OFFSET_C = 3'd2;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd3;
    localparam logic [2:0] REG_ORDER = 3'd4;

    localparam logic [31:0] COEFF_A_RST = 32'd19661;
    localparam logic [31:0] COEFF_B_RST = 32'd3277;
    localparam logic [31:0] OFFSET_C_RST = 32'd6554;
    localparam logic [31:0] OUTPUT_GAIN_RST = 32'd65536;
    localparam logic [5:0] ORDER_RST = 6'd10;

    localparam logic signed [47:0] Q_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] Q_MIN = -48'sh0000_8000_0000;

    typedef struct packed {
        logic sat;
        q16_t val;
    } clip_t;

    function automatic clip_t clip48(input logic signed [47:0] x);
        clip_t r;
        if (x > Q_MAX)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (x < Q_MIN)
        begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/nrg_in_if.sv -----
// input channel: one drive sample and its restart bit per transfer
// depends on nrg_pkg
interface nrg_in_if;
    import nrg_pkg::*;

    logic valid;
    logic ready;
    q16_t drive_sample;
    logic restart;

    modport source (output valid, drive_sample, restart, input ready);
    modport sink (input valid, drive_sample, restart, output ready);
endinterface

// ----- rtl/nrg_out_if.sv -----
// result channel: one output sample and its saturation flag per transfer
// depends on nrg_pkg
interface nrg_out_if;
    import nrg_pkg::*;

    logic valid;
    logic ready;
    q16_t narma_out;
    logic saturated;

    modport source (output valid, narma_out, saturated, input ready);
    modport sink (input valid, narma_out, saturated, output ready);
endinterface

// ----- rtl/narma_recurrence_generator.sv -----
// narma series generator, q16.16, one shared 32x32 multiplier under a sequencer
// depends on nrg_pkg, nrg_in_if, nrg_out_if
//
//  channel     dir   handshake         payload
//  sample_in   in    valid/ready       drive_sample[31:0] signed, restart
//  result_out  out   valid/ready       narma_out[31:0] signed, saturated
//  apb         in    psel/penable      paddr[4:0], pwdata/prdata[31:0], pready=1
//
// one item goes from transfer to result through the eight steps after the transfer
// cycle, set by five products going one after another through the multiplier.
// the first item after a write to order, unless it restarts, also walks the output
// ring to rebuild the window sum over the window length (order clamped to 1..MAX_ORDER).
// reset and restart clear history at once (ring valid bits, no clearing pass).
// a finished result waits in the output register; the next sample is taken
// meanwhile, and only the last step stalls while that register is still full.
module narma_recurrence_generator #(
    parameter int MAX_ORDER = 32,
    parameter int INPUT_LAG = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    nrg_in_if.sink       sample_in,
    nrg_out_if.source    result_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import nrg_pkg::*;

    localparam int PTR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PE_W = PTR_W + 1;
    localparam int K_W = $clog2(MAX_ORDER + 1);
    localparam int SUM_W = 32 + ((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 0);
    localparam int LAG_LAST = INPUT_LAG - 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_ORDER - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECOMP,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_U,
        ST_MUL_S,
        ST_SUM,
        ST_PRE,
        ST_MUL_G,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] coeff_a_reg, coeff_b_reg, offset_c_reg, gain_reg;
    logic [5:0]  order_reg;

    // history
    logic [PTR_W-1:0]        ptr_reg;
    logic [MAX_ORDER-1:0]    ring_vld_reg;
    logic signed [SUM_W-1:0] sum_reg;
    q16_t                    prev_reg;
    q16_t                    dly_reg [INPUT_LAG];
    logic                    dirty_reg;

    // window rebuild
    logic [PTR_W-1:0] raddr_reg;
    logic [K_W-1:0]   cnt_reg;
    logic             pend_reg;

    // ring memory and its registered read port
    logic [31:0]      ring_mem [MAX_ORDER];
    logic [31:0]      rd_data_reg;
    logic             rd_vld_reg;
    logic [PTR_W-1:0] rd_addr;

    // datapath
    logic signed [63:0] p_reg;
    q16_t u_reg, ta_reg, tb1_reg, tu1_reg, tb_reg, tu_reg, pre_reg;
    logic sat_reg;
    q16_t mul_x, mul_y;

    // result register
    logic out_valid_reg;
    q16_t out_data_reg;
    logic out_sat_reg;

    logic [K_W-1:0]  k;
    logic [15:0]     ord16;
    logic [PE_W-1:0] ev_tmp;
    logic [PTR_W-1:0] ev_addr;
    q16_t            ev_val;
    clip_t           q_cl, s_cl, tu_cl, pre_cl;
    logic            in_xfer, cfg_wr, fin_go;

    assign ord16 = {10'd0, order_reg};

    always_comb
    begin
        if (ord16 == 16'd0)
            k = K_W'(1);
        else if (ord16 > 16'(MAX_ORDER))
            k = K_W'(MAX_ORDER);
        else
            k = K_W'(ord16);
    end

    // slot of the output leaving the window after this step
    assign ev_tmp = PE_W'(ptr_reg) + PE_W'(MAX_ORDER) - PE_W'(k);
    assign ev_addr = (ev_tmp >= PE_W'(MAX_ORDER)) ? PTR_W'(ev_tmp - PE_W'(MAX_ORDER))
                                                  : PTR_W'(ev_tmp);
    assign rd_addr = (state_reg == ST_RECOMP) ? raddr_reg : ev_addr;
    assign ev_val = rd_vld_reg ? q16_t'(rd_data_reg) : '0;

    // product >>> 16 with floor is the upper 48 bits
    assign q_cl = clip48(p_reg[63:16]);
    assign s_cl = clip48(48'(sum_reg));
    assign tu_cl = clip48(48'(tu1_reg) + 48'(tu1_reg >>> 1));
    assign pre_cl = clip48(48'(ta_reg) + 48'(tb_reg) + 48'(tu_reg)
                           + 48'($signed(offset_c_reg)));

    always_comb
    begin
        mul_x = $signed(coeff_a_reg);
        mul_y = prev_reg;
        case (state_reg)
            ST_MUL_B:
            begin
                mul_x = $signed(coeff_b_reg);
                mul_y = prev_reg;
            end
            ST_MUL_U:
            begin
                mul_x = dly_reg[0];
                mul_y = dly_reg[LAG_LAST];
            end
            ST_MUL_S:
            begin
                mul_x = tb1_reg;
                mul_y = s_cl.val;
            end
            ST_MUL_G:
            begin
                mul_x = $signed(gain_reg);
                mul_y = pre_reg;
            end
            default:
            begin
                mul_x = $signed(coeff_a_reg);
                mul_y = prev_reg;
            end
        endcase
    end

    assign in_xfer = sample_in.valid && (state_reg == ST_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || result_out.ready);

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign result_out.valid = out_valid_reg;
    assign result_out.narma_out = out_data_reg;
    assign result_out.saturated = out_sat_reg;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_COEFF_A:     prdata = coeff_a_reg;
            REG_COEFF_B:     prdata = coeff_b_reg;
            REG_OFFSET_C:    prdata = offset_c_reg;
            REG_OUTPUT_GAIN: prdata = gain_reg;
            REG_ORDER:       prdata = {26'd0, order_reg};
            default:         prdata = '0;
        endcase
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (fin_go)
            ring_mem[ptr_reg] <= q_cl.val;
        rd_data_reg <= ring_mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // the final product is held while the result waits
        if (state_reg != ST_FIN)
            p_reg <= mul_x * mul_y;
        if (in_xfer)
            u_reg <= sample_in.drive_sample;
        case (state_reg)
            ST_MUL_B: ta_reg <= q_cl.val;
            ST_MUL_U: tb1_reg <= q_cl.val;
            ST_MUL_S: tu1_reg <= q_cl.val;
            ST_SUM:
            begin
                tb_reg <= q_cl.val;
                tu_reg <= tu_cl.val;
            end
            ST_PRE:   pre_reg <= pre_cl.val;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            coeff_a_reg <= COEFF_A_RST;
            coeff_b_reg <= COEFF_B_RST;
            offset_c_reg <= OFFSET_C_RST;
            gain_reg <= OUTPUT_GAIN_RST;
            order_reg <= ORDER_RST;
            ptr_reg <= '0;
            ring_vld_reg <= '0;
            sum_reg <= '0;
            prev_reg <= '0;
            for (int i = 0; i < INPUT_LAG; i++)
                dly_reg[i] <= '0;
            dirty_reg <= 1'b0;
            raddr_reg <= '0;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_sat_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ring_vld_reg[rd_addr];

            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_COEFF_A:     coeff_a_reg <= pwdata;
                    REG_COEFF_B:     coeff_b_reg <= pwdata;
                    REG_OFFSET_C:    offset_c_reg <= pwdata;
                    REG_OUTPUT_GAIN: gain_reg <= pwdata;
                    REG_ORDER:
                    begin
                        order_reg <= pwdata[5:0];
                        dirty_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (out_valid_reg && result_out.ready && !fin_go)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        sat_reg <= 1'b0;
                        if (sample_in.restart)
                        begin
                            ptr_reg <= '0;
                            ring_vld_reg <= '0;
                            sum_reg <= '0;
                            prev_reg <= '0;
                            for (int i = 0; i < INPUT_LAG; i++)
                                dly_reg[i] <= '0;
                            dirty_reg <= 1'b0;
                            state_reg <= ST_MUL_A;
                        end
                        else if (dirty_reg)
                        begin
                            sum_reg <= '0;
                            raddr_reg <= (ptr_reg == '0) ? PTR_LAST : ptr_reg - 1'b1;
                            cnt_reg <= '0;
                            pend_reg <= 1'b0;
                            state_reg <= ST_RECOMP;
                        end
                        else
                            state_reg <= ST_MUL_A;
                    end
                end
                ST_RECOMP:
                begin
                    // one ring read issued per cycle, each added in the cycle after
                    if (pend_reg)
                        sum_reg <= sum_reg + SUM_W'(ev_val);
                    if (cnt_reg != k)
                    begin
                        raddr_reg <= (raddr_reg == '0) ? PTR_LAST : raddr_reg - 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            dirty_reg <= 1'b0;
                            state_reg <= ST_MUL_A;
                        end
                    end
                end
                ST_MUL_A: state_reg <= ST_MUL_B;
                ST_MUL_B:
                begin
                    sat_reg <= sat_reg | q_cl.sat;
                    state_reg <= ST_MUL_U;
                end
                ST_MUL_U:
                begin
                    sat_reg <= sat_reg | q_cl.sat;
                    state_reg <= ST_MUL_S;
                end
                ST_MUL_S:
                begin
                    sat_reg <= sat_reg | q_cl.sat | s_cl.sat;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sat_reg <= sat_reg | q_cl.sat | tu_cl.sat;
                    state_reg <= ST_PRE;
                end
                ST_PRE:
                begin
                    sat_reg <= sat_reg | pre_cl.sat;
                    state_reg <= ST_MUL_G;
                end
                ST_MUL_G: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= q_cl.val;
                        out_sat_reg <= sat_reg | q_cl.sat;
                        ring_vld_reg[ptr_reg] <= 1'b1;
                        ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                        sum_reg <= sum_reg + SUM_W'(q_cl.val) - SUM_W'(ev_val);
                        prev_reg <= q_cl.val;
                        for (int i = LAG_LAST; i > 0; i--)
                            dly_reg[i] <= dly_reg[i-1];
                        dly_reg[0] <= u_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
